@@ design/ike_sa_payload_parser_unit_macros.svh @@
// Assertion macros for the SA payload parser.
`ifndef IKE_SA_PAYLOAD_PARSER_UNIT_MACROS_SVH
`define IKE_SA_PAYLOAD_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IKESA_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IKESA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ikesa_pkg.sv @@
// Shared types and constants of the SA payload parser.
`default_nettype none

package ikesa_pkg;

    localparam logic [1:0] KIND_PROPOSAL  = 2'd0;
    localparam logic [1:0] KIND_SPI       = 2'd1;
    localparam logic [1:0] KIND_TRANSFORM = 2'd2;
    localparam logic [1:0] KIND_STATUS    = 2'd3;

    localparam logic [15:0] KEY_ATTR  = 16'h800e;
    localparam logic [15:0] HDR_BYTES = 16'd8;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_payload;
    } t_ike_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  proposal_number;
        logic [7:0]  proto_id;
        logic [7:0]  spi_length;
        logic [7:0]  declared_transforms;
        logic [7:0]  spi_data;
        logic [7:0]  xform_type;
        logic [15:0] xform_id;
        logic [15:0] key_len;
        logic        status;
        logic        last_result;
    } t_ike_res;

    // Results produced by one byte, in order: slot0 first.
    typedef struct packed {
        logic [1:0] count;
        t_ike_res   slot0;
        t_ike_res   slot1;
    } t_ike_push;

endpackage

`default_nettype wire

@@ design/ikesa_parse_core.sv @@
// Parser state and per-byte decode; emits up to two results per byte.
`default_nettype none

module ikesa_parse_core
    import ikesa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_take,
    input  wire t_ike_in   i_in,
    output t_ike_push      o_push
);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_SPI  = 3'd1;
    localparam logic [2:0] PH_TR   = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_po, n_po;
    logic [15:0] r_pl, n_pl;
    logic        r_pmore, n_pmore;
    logic [31:0] r_hdr, n_hdr;
    logic [15:0] r_to, n_to;
    logic [15:0] r_tl, n_tl;
    logic        r_tmore, n_tmore;
    logic [39:0] r_rec, n_rec;
    logic [31:0] r_attr, n_attr;
    logic        r_err, n_err;

    logic [7:0]  b;
    logic [15:0] po_inc;
    logic        rec_v;
    logic [1:0]  rec_kind;
    logic [7:0]  rec_spi;
    logic        ok;
    logic [16:0] lim;
    logic [15:0] tl_new;
    logic [31:0] out_hdr;
    logic [39:0] out_tr;
    t_ike_res    rec;
    t_ike_res    stat;

    assign b      = i_in.byte_in;
    assign po_inc = r_po + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_po     = r_po;
        n_pl     = r_pl;
        n_pmore  = r_pmore;
        n_hdr    = r_hdr;
        n_to     = r_to;
        n_tl     = r_tl;
        n_tmore  = r_tmore;
        n_rec    = r_rec;
        n_attr   = r_attr;
        n_err    = r_err;
        rec_v    = 1'b0;
        rec_kind = KIND_PROPOSAL;
        rec_spi  = 8'd0;
        tl_new   = {r_tl[15:8], b};
        lim      = {1'b0, r_pl} + 17'd3;

        if (!r_err && r_phase != PH_DONE) begin
            n_po = po_inc;
            case (r_phase)
                PH_HDR: begin
                    case (r_po)
                        16'd0: n_pmore = (b != 8'd0);
                        16'd2: n_pl = {b, 8'd0};
                        16'd3: begin
                            n_pl = {r_pl[15:8], b};
                            if ({r_pl[15:8], b} < HDR_BYTES) begin
                                n_err   = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end
                        16'd4: n_hdr = {b, 24'd0};
                        16'd5: n_hdr = {r_hdr[31:24], b, 16'd0};
                        16'd6: begin
                            n_hdr = {r_hdr[31:16], b, 8'd0};
                            if ({8'd0, b} > r_pl - HDR_BYTES) begin
                                n_err   = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end
                        16'd7: begin
                            n_hdr    = {r_hdr[31:8], b};
                            rec_v    = 1'b1;
                            rec_kind = KIND_PROPOSAL;
                            if (b != 8'd0) begin
                                n_phase = PH_SPI;
                            end else if (po_inc == r_pl) begin
                                if (!r_pmore) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_HDR;
                                    n_po    = 16'd0;
                                end
                            end else begin
                                n_phase = PH_TR;
                                n_to    = 16'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_SPI: begin
                    rec_v    = 1'b1;
                    rec_kind = KIND_SPI;
                    rec_spi  = b;
                    if (po_inc == HDR_BYTES + {8'd0, r_hdr[15:8]}) begin
                        if (po_inc == r_pl) begin
                            if (!r_pmore) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_HDR;
                                n_po    = 16'd0;
                            end
                        end else begin
                            n_phase = PH_TR;
                            n_to    = 16'd0;
                        end
                    end
                end
                PH_TR: begin
                    n_to = r_to + 16'd1;
                    if (r_to == 16'd0) begin
                        if (r_pl >= r_po && (r_pl - r_po) < HDR_BYTES) begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_tmore = (b != 8'd0);
                            n_rec   = 40'd0;
                            n_attr  = 32'd0;
                        end
                    end else if (r_to == 16'd2) begin
                        n_tl = {b, 8'd0};
                    end else if (r_to == 16'd3) begin
                        n_tl = tl_new;
                        // Transform must fit in what is left of the proposal.
                        if (tl_new < HDR_BYTES ||
                            (lim >= {1'b0, r_po} && {1'b0, tl_new} > lim - {1'b0, r_po}))
                        begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end else if (r_to == 16'd4) begin
                        n_rec = {b, r_rec[31:0]};
                    end else if (r_to == 16'd6) begin
                        n_rec = {r_rec[39:32], b, r_rec[23:0]};
                    end else if (r_to == 16'd7) begin
                        n_rec = {r_rec[39:24], b, r_rec[15:0]};
                    end else if (r_to >= HDR_BYTES) begin
                        n_attr = {r_attr[23:0], b};
                        if (r_to[1:0] == 2'b11 && n_attr[31:16] == KEY_ATTR) begin
                            n_rec = {r_rec[39:16], n_attr[15:0]};
                        end
                    end
                    if (!n_err && r_to >= 16'd7 &&
                        ({1'b0, r_to} + 17'd1) == {1'b0, n_tl}) begin
                        rec_v    = 1'b1;
                        rec_kind = KIND_TRANSFORM;
                        if (po_inc == r_pl) begin
                            if (!r_pmore) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_HDR;
                                n_po    = 16'd0;
                            end
                        end else if (!n_tmore) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_to = 16'd0;
                        end
                    end
                end
                PH_SKIP: begin
                    if (po_inc == r_pl) begin
                        if (!r_pmore) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_HDR;
                            n_po    = 16'd0;
                        end
                    end
                end
                default: ;
            endcase
        end

        // A header cut off before its length field is complete is tolerated.
        ok = !n_err && (n_phase == PH_DONE || (n_phase == PH_HDR && n_po < 16'd4));

        // Record fields are taken before the end-of-payload clear.
        out_hdr = n_hdr;
        out_tr  = n_rec;

        if (i_in.end_of_payload) begin
            n_phase = PH_HDR;
            n_po    = 16'd0;
            n_pl    = 16'd0;
            n_pmore = 1'b0;
            n_hdr   = 32'd0;
            n_to    = 16'd0;
            n_tl    = 16'd0;
            n_tmore = 1'b0;
            n_rec   = 40'd0;
            n_attr  = 32'd0;
            n_err   = 1'b0;
        end
    end

    always_comb begin
        rec                     = '0;
        rec.kind                = rec_kind;
        rec.proposal_number     = out_hdr[31:24];
        rec.proto_id            = out_hdr[23:16];
        rec.spi_length          = out_hdr[15:8];
        rec.declared_transforms = out_hdr[7:0];
        rec.spi_data            = rec_spi;
        if (rec_kind == KIND_TRANSFORM) begin
            rec.xform_type = out_tr[39:32];
            rec.xform_id   = out_tr[31:16];
            rec.key_len    = out_tr[15:0];
        end
        stat             = '0;
        stat.kind        = KIND_STATUS;
        stat.status      = !ok;
        stat.last_result = 1'b1;
    end

    always_comb begin
        o_push.slot1 = stat;
        if (rec_v) begin
            o_push.slot0 = rec;
        end else begin
            o_push.slot0 = stat;
        end
        if (!i_take) begin
            o_push.count = 2'd0;
        end else begin
            o_push.count = {1'b0, rec_v} + {1'b0, i_in.end_of_payload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_po    <= 16'd0;
            r_pl    <= 16'd0;
            r_pmore <= 1'b0;
            r_hdr   <= 32'd0;
            r_to    <= 16'd0;
            r_tl    <= 16'd0;
            r_tmore <= 1'b0;
            r_rec   <= 40'd0;
            r_attr  <= 32'd0;
            r_err   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_po    <= n_po;
            r_pl    <= n_pl;
            r_pmore <= n_pmore;
            r_hdr   <= n_hdr;
            r_to    <= n_to;
            r_tl    <= n_tl;
            r_tmore <= n_tmore;
            r_rec   <= n_rec;
            r_attr  <= n_attr;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ design/ikesa_out_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one while the reader is ready.
`default_nettype none

module ikesa_out_fifo
    import ikesa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ike_push i_push,
    input  wire logic      i_pop_ready,
    output logic           o_room,
    output logic           o_valid,
    output t_ike_res       o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = PTR_W + 1;

    t_ike_res           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic               pop;

    assign o_valid = (r_lvl != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_lvl <= LVL_W'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.count);
        n_rd  = r_rd + PTR_W'(pop);
        n_lvl = r_lvl + LVL_W'(i_push.count) - LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
    end

endmodule

`default_nettype wire

@@ design/ike_sa_payload_parser_unit.sv @@
// Top level of the streaming IKEv2 SA payload parser.
//
// Input channel: one payload byte per transaction (byte_in), with
// end_of_payload set on the final byte. Output channel: result records,
// kind 0 proposal header, 1 SPI byte, 2 transform, 3 end status.
// Each byte is decoded in the cycle it is accepted and its results land
// in a four-entry result queue, registered behind any results still
// waiting. Throughput is one byte per cycle while the queue has room; a
// byte yields at most two results (a record plus the end status on the
// final byte), and the single-read port of the queue drains one result a
// cycle while the receiver is ready.
// o_in_ready is high while the queue has room for two results, so a
// stalled receiver backs up the byte stream only once the queue holds
// three entries; nothing is dropped. The end status carries last_result;
// on status fail every record of that payload is to be discarded.
// Parser state returns to its idle values after each end status.
// Reset (synchronous, active low) empties the queue and sets the parser
// to wait for a proposal header.
`default_nettype none

`include "ike_sa_payload_parser_unit_macros.svh"

module ike_sa_payload_parser_unit
    import ikesa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ike_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_ike_res      o_out
);

    logic      take;
    t_ike_push push;

    // Accept only while the queue can absorb the worst case of two results.
    assign take = i_in_valid && o_in_ready;

    ikesa_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in),
        .o_push  (push)
    );

    ikesa_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (i_out_ready),
        .o_room      (o_in_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out)
    );

    // Final byte always enqueues the status.
    `IKESA_ASSERT_HOLD(a_eop_push, take && i_in.end_of_payload, push.count != 2'd0, "eop without status")
    // No results without an accepted byte.
    `IKESA_ASSERT_HOLD(a_no_spurious, !take, push.count == 2'd0, "push without accepted byte")
    // last_result marks exactly the status record.
    `IKESA_ASSERT_HOLD(a_last_kind, o_out_valid, o_out.last_result == (o_out.kind == KIND_STATUS), "last_result mismatch")
    // Queue is non-empty the cycle after a final byte.
    `IKESA_ASSERT_NEXT(a_eop_visible, take && i_in.end_of_payload, o_out_valid, "status not queued")

endmodule

`default_nettype wire

@@ bench/tb_ike_sa_payload_parser_unit.sv @@
// Self-checking testbench for the streaming IKEv2 SA payload parser.
`timescale 1ns / 100ps

module tb_ike_sa_payload_parser_unit;
    import ikesa_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int TARGET_BYTES = 1250;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 20;
    // Timeout allows several times the slowest legal run.
    localparam int TIMEOUT_NS   = 2_000_000;

    // Parser phases of the bench's own decoder.
    typedef enum logic [2:0] {
        PS_HEADER,
        PS_SPI,
        PS_TRANSFORM,
        PS_SKIP,
        PS_DONE
    } t_parse_state;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_ike_in  in_item   = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_ike_res out_rec;

    ike_sa_payload_parser_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rec)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus and result stores
    // ------------------------------------------------------------------
    t_ike_in    byte_queue[$];         // payload bytes waiting to be driven
    t_ike_res   expected_records[$];   // decoded records not yet seen on the output
    logic [7:0] payload_buf[$];        // payload under construction

    int total_bytes     = 0;
    int payloads_queued = 0;
    int bytes_taken     = 0;
    int records_seen    = 0;
    int failed_payloads = 0;
    int mismatch_count  = 0;
    int kind_count[4];

    // Handshake flags, sampled at the rising edge and used by the drivers
    // at the following falling edge.
    bit in_fire_q  = 1'b0;
    bit out_fire_q = 1'b0;

    // ------------------------------------------------------------------
    // Decoder state: mirrors what the parser keeps between bytes
    // ------------------------------------------------------------------
    t_parse_state ps;
    int           prop_off;
    int           prop_len;
    bit           prop_more;
    logic [31:0]  hdr;        // proposal number, protocol, SPI size, count
    int           tr_off;
    int           tr_len;
    bit           tr_more;
    logic [39:0]  tr_rec;     // type, id, key length
    logic [31:0]  attr;
    bit           parse_err;

    function automatic void clear_parser();
        ps        = PS_HEADER;
        prop_off  = 0;
        prop_len  = 0;
        prop_more = 1'b0;
        hdr       = '0;
        tr_off    = 0;
        tr_len    = 0;
        tr_more   = 1'b0;
        tr_rec    = '0;
        attr      = '0;
        parse_err = 1'b0;
    endfunction

    function automatic void emit_record(logic [1:0] kind, logic [7:0] spi, logic st);
        t_ike_res r;
        r = '0;
        r.kind = kind;
        if (kind != KIND_STATUS) begin
            r.proposal_number     = hdr[31:24];
            r.proto_id            = hdr[23:16];
            r.spi_length          = hdr[15:8];
            r.declared_transforms = hdr[7:0];
            r.spi_data            = spi;
        end
        if (kind == KIND_TRANSFORM) begin
            r.xform_type = tr_rec[39:32];
            r.xform_id   = tr_rec[31:16];
            r.key_len    = tr_rec[15:0];
        end
        if (kind == KIND_STATUS) begin
            r.status      = st;
            r.last_result = 1'b1;
        end
        expected_records.push_back(r);
    endfunction

    function automatic void fail_parse();
        parse_err = 1'b1;
        ps        = PS_DONE;
    endfunction

    // A non-final proposal hands over to the next header; the final one
    // ends the payload cleanly.
    function automatic void end_proposal();
        if (!prop_more) begin
            ps = PS_DONE;
        end else begin
            ps       = PS_HEADER;
            prop_off = 0;
        end
    endfunction

    function automatic void enter_body();
        if (prop_off == prop_len) begin
            end_proposal();
        end else begin
            ps     = PS_TRANSFORM;
            tr_off = 0;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int po;
        int t;
        po       = prop_off;
        prop_off = (po + 1) & 16'hffff;
        case (ps)
            PS_HEADER: begin
                case (po)
                    0: prop_more = (b != 8'h00);
                    2: prop_len = int'(b) << 8;
                    3: begin
                        prop_len = prop_len | int'(b);
                        if (prop_len < int'(HDR_BYTES)) fail_parse();
                    end
                    4: hdr[31:24] = b;
                    5: hdr[23:16] = b;
                    6: begin
                        hdr[15:8] = b;
                        // SPI must fit inside the proposal
                        if (int'(b) > prop_len - int'(HDR_BYTES)) fail_parse();
                    end
                    7: begin
                        hdr[7:0] = b;
                        emit_record(KIND_PROPOSAL, 8'h00, 1'b0);
                        if (b != 8'h00) ps = PS_SPI;
                        else enter_body();
                    end
                    default: ;
                endcase
            end
            PS_SPI: begin
                emit_record(KIND_SPI, b, 1'b0);
                if (prop_off == int'(HDR_BYTES) + int'(hdr[15:8])) enter_body();
            end
            PS_TRANSFORM: begin
                t      = tr_off;
                tr_off = (t + 1) & 16'hffff;
                if (t == 0) begin
                    // no room left for a transform header (offset past the end never fails)
                    if (prop_len >= po && prop_len - po < int'(HDR_BYTES)) begin
                        fail_parse();
                        return;
                    end
                    tr_more = (b != 8'h00);
                    tr_rec  = '0;
                    attr    = '0;
                end else if (t == 2) begin
                    tr_len = int'(b) << 8;
                end else if (t == 3) begin
                    tr_len = tr_len | int'(b);
                    if (tr_len < int'(HDR_BYTES) ||
                        (prop_len + 3 >= po && tr_len > prop_len - po + 3)) begin
                        fail_parse();
                        return;
                    end
                end else if (t == 4) begin
                    tr_rec[39:32] = b;
                end else if (t == 6) begin
                    tr_rec[31:24] = b;
                end else if (t == 7) begin
                    tr_rec[23:16] = b;
                end else if (t >= int'(HDR_BYTES)) begin
                    // attributes are whole 4-byte words; a short tail never completes
                    attr = {attr[23:0], b};
                    if (((t - int'(HDR_BYTES)) & 3) == 3 && attr[31:16] == KEY_ATTR)
                        tr_rec[15:0] = attr[15:0];
                end
                if (t >= 7 && t + 1 == tr_len) begin
                    emit_record(KIND_TRANSFORM, 8'h00, 1'b0);
                    if (prop_off == prop_len) end_proposal();
                    else if (!tr_more) ps = PS_SKIP;
                    else tr_off = 0;
                end
            end
            PS_SKIP: begin
                if (prop_off == prop_len) end_proposal();
            end
            default: ;
        endcase
    endfunction

    // One accepted transaction: decode, and close the payload on its last byte.
    function automatic void predict_byte(t_ike_in it);
        bit ok;
        if (!parse_err && ps != PS_DONE) decode_byte(it.byte_in);
        if (it.end_of_payload) begin
            // a header cut after fewer than 4 bytes is tolerated
            ok = !parse_err && (ps == PS_DONE || (ps == PS_HEADER && prop_off < 4));
            emit_record(KIND_STATUS, 8'h00, !ok);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s got 0x%0h want 0x%0h",
                                      records_seen, name, got, want));
    endtask

    task automatic check_record(input t_ike_res got);
        t_ike_res want;
        if (expected_records.size() == 0) begin
            report_mismatch($sformatf("record %0d (kind %0d) with nothing pending",
                                      records_seen, got.kind));
        end else begin
            want = expected_records.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("proposal_number", got.proposal_number, want.proposal_number);
            compare_field("proto_id", got.proto_id, want.proto_id);
            compare_field("spi_length", got.spi_length, want.spi_length);
            compare_field("declared_transforms", got.declared_transforms,
                          want.declared_transforms);
            compare_field("spi_data", got.spi_data, want.spi_data);
            compare_field("xform_type", got.xform_type, want.xform_type);
            compare_field("xform_id", got.xform_id, want.xform_id);
            compare_field("key_len", got.key_len, want.key_len);
            compare_field("status", got.status, want.status);
            compare_field("last_result", got.last_result, want.last_result);
        end
        if (!$isunknown(got.kind)) kind_count[got.kind]++;
        if (got.kind == KIND_STATUS && got.status == 1'b1) failed_payloads++;
        records_seen++;
    endtask

    // Monitor: both handshakes are judged on values settled before the edge.
    always @(posedge clk) begin
        in_fire_q  = rst_n && in_valid && in_ready;
        out_fire_q = rst_n && out_valid && out_ready;
        if (in_fire_q) begin
            predict_byte(in_item);
            bytes_taken++;
        end
        if (out_fire_q) check_record(out_rec);
    end

    // ------------------------------------------------------------------
    // Drivers (falling edge). Each transaction draws its own wait; a quiet
    // mode toggles now and then to give back-to-back stretches.
    // ------------------------------------------------------------------
    int in_gap    = 0;
    bit in_quiet  = 1'b0;
    int out_stall = 0;
    bit out_quiet = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire_q) begin
            // hold the transaction until it is taken
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap--;
        end else if (byte_queue.size() != 0) begin
            in_valid <= 1'b1;
            in_item  <= byte_queue.pop_front();
            if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
            in_gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_fire_q) begin
                if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
                out_stall = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (out_stall > 0) begin
                out_ready <= 1'b0;
                out_stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload construction
    // ------------------------------------------------------------------
    task automatic queue_payload();
        t_ike_in it;
        int      i;
        if (payload_buf.size() == 0) payload_buf.push_back($urandom_range(0, 255));
        for (i = 0; i < payload_buf.size(); i++) begin
            it.byte_in        = payload_buf[i];
            it.end_of_payload = (i == payload_buf.size() - 1);
            byte_queue.push_back(it);
        end
        payloads_queued++;
        payload_buf.delete();
    endtask

    // Appends one well-formed proposal with random content; lengths are
    // patched once the body is known. Now and then the last/more flags are
    // inverted and trailing pad bytes are added.
    task automatic add_proposal(input bit final_one);
        int          start;
        int          tstart;
        int          n_spi;
        int          n_tr;
        int          n_attr;
        int          n_tail;
        int          n_pad;
        int          k;
        int          j;
        logic [15:0] len16;
        logic [15:0] atype;
        logic [7:0]  flag;
        start = payload_buf.size();
        n_spi = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
        n_tr  = $urandom_range(0, 3);
        flag  = final_one ? 8'h00 : $urandom_range(1, 255);
        if ($urandom_range(0, 9) == 0) flag = final_one ? 8'h02 : 8'h00;
        payload_buf.push_back(flag);
        payload_buf.push_back($urandom_range(0, 255));
        payload_buf.push_back(8'h00);
        payload_buf.push_back(8'h00);
        payload_buf.push_back($urandom_range(0, 255));
        payload_buf.push_back($urandom_range(0, 255));
        payload_buf.push_back(n_spi);
        payload_buf.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : n_tr);
        for (j = 0; j < n_spi; j++) payload_buf.push_back($urandom_range(0, 255));
        for (k = 0; k < n_tr; k++) begin
            tstart = payload_buf.size();
            n_attr = $urandom_range(0, 3);
            n_tail = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            flag   = (k == n_tr - 1) ? 8'h00 : $urandom_range(1, 255);
            if ($urandom_range(0, 9) == 0) flag = (k == n_tr - 1) ? 8'h03 : 8'h00;
            payload_buf.push_back(flag);
            payload_buf.push_back($urandom_range(0, 255));
            payload_buf.push_back(8'h00);
            payload_buf.push_back(8'h00);
            payload_buf.push_back($urandom_range(0, 255));
            payload_buf.push_back($urandom_range(0, 255));
            payload_buf.push_back($urandom_range(0, 255));
            payload_buf.push_back($urandom_range(0, 255));
            for (j = 0; j < n_attr; j++) begin
                // mostly key length attributes, so the last-one-wins rule is hit
                atype = ($urandom_range(0, 2) != 0) ? KEY_ATTR : $urandom_range(0, 65535);
                payload_buf.push_back(atype[15:8]);
                payload_buf.push_back(atype[7:0]);
                payload_buf.push_back($urandom_range(0, 255));
                payload_buf.push_back($urandom_range(0, 255));
            end
            for (j = 0; j < n_tail; j++) payload_buf.push_back($urandom_range(0, 255));
            len16 = payload_buf.size() - tstart;
            payload_buf[tstart + 2] = len16[15:8];
            payload_buf[tstart + 3] = len16[7:0];
        end
        n_pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        for (j = 0; j < n_pad; j++) payload_buf.push_back($urandom_range(0, 255));
        len16 = payload_buf.size() - start;
        payload_buf[start + 2] = len16[15:8];
        payload_buf[start + 3] = len16[7:0];
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int n_prop;
        int p;
        int cut;
        int n;
        int j;
        clear_parser();
        for (j = 0; j < 4; j++) kind_count[j] = 0;

        // Directed: lone byte (short header, ok), length below 8,
        // SPI that overruns the proposal, and a closing proposal with
        // all-ones proposal number and protocol ID and four SPI bytes.
        payload_buf = '{8'ha5};
        queue_payload();
        payload_buf = '{8'h00, 8'h00, 8'h00, 8'h05};
        queue_payload();
        payload_buf = '{8'h00, 8'hff, 8'h00, 8'h08, 8'h01, 8'h03, 8'h01, 8'h00};
        queue_payload();
        payload_buf = '{8'h00, 8'h00, 8'h00, 8'h0c, 8'hff, 8'hff, 8'h04, 8'h00,
                        8'hde, 8'had, 8'hbe, 8'hef};
        queue_payload();

        // Random: mostly well-formed payloads, plus corrupted, truncated
        // and pure noise ones.
        while (byte_queue.size() < TARGET_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                n_prop = $urandom_range(1, 3);
                for (p = 0; p < n_prop; p++) add_proposal(p == n_prop - 1);
                if (pick >= 60 && pick < 75) begin
                    if ($urandom_range(0, 1) == 1) begin
                        // short first proposal length
                        payload_buf[2] = 8'h00;
                        payload_buf[3] = $urandom_range(0, 12);
                    end else begin
                        payload_buf[$urandom_range(0, payload_buf.size() - 1)] =
                            $urandom_range(0, 255);
                    end
                end else if (pick >= 75) begin
                    cut = $urandom_range(1, payload_buf.size() - 1);
                    while (payload_buf.size() > cut)
                        payload_buf.delete(payload_buf.size() - 1);
                end
            end else begin
                n = $urandom_range(1, 24);
                for (j = 0; j < n; j++) payload_buf.push_back($urandom_range(0, 255));
            end
            queue_payload();
        end
        total_bytes = byte_queue.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Counters only move at rising edges, so polling on falling edges is race free.
        while (bytes_taken < total_bytes || expected_records.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d payloads; %0d of them ended in parse failure",
                 bytes_taken, payloads_queued, failed_payloads);
        $display("records checked: %0d headers, %0d SPI bytes, %0d transforms, %0d statuses",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (mismatch_count == 0) begin
            $display("ike_sa_payload_parser_unit verification clean");
        end else begin
            $display("ike_sa_payload_parser_unit verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ike_sa_payload_parser_unit verification failed");
        $finish;
    end

endmodule
